// File: hdl/bpdc_pkg.sv
// Shared types and constants for the de Casteljau curve point evaluator.
// Used by every module of the block but bpdc_ram; depends on nothing.

package bpdc_pkg;

   localparam int COORD_W   = 24;   // signed Q15.8 coordinate
   localparam int IDX_W     = 4;    // control point index field
   localparam int T_FIELD_W = 17;   // curve parameter field
   localparam int COUNT_W   = 5;    // point count register

   localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = 5'd4;
   localparam int COUNT_MIN = 2;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_EVAL  = 1'b1;

   // A short row waits this less its length before its next pass, so that every
   // read sees the interpolation it needs (read, difference, multiply, sum and write).
   localparam int RD_TO_RD_MIN = 5;
   localparam int GAP_W        = 3;

   typedef struct packed {
      logic                        action;
      logic [IDX_W-1:0]            point_index;
      logic signed [COORD_W-1:0]   point_x;
      logic signed [COORD_W-1:0]   point_y;
      logic [T_FIELD_W-1:0]        t_value;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0]   curve_x;
      logic signed [COORD_W-1:0]   curve_y;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic store_write;   // write word accepted: store point if index in range
      logic load_t;        // evaluate word accepted: latch saturated t
      logic rd_en;         // read one row element
      logic src_stored;    // element comes from the control point table
      logic first;         // first element of a pass: load only, no interpolation
      logic last;          // element that completes the final interpolation
      logic load_out;      // move finished point into the output register
   } cmd_type;

endpackage

// File: hdl/bpdc_ram.sv
// Generic single write port, single read port RAM with registered read data.
// Stands alone; no package dependency.

module bpdc_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/bpdc_lerp.sv
// One coordinate lane of the interpolation pipeline: difference, multiply, round.
// Depends on bpdc_pkg for the coordinate width.

module bpdc_lerp #(
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   advance,
   input  logic signed [bpdc_pkg::COORD_W-1:0]    cur,
   input  logic [T_FRAC_BITS:0]                   t,
   output logic signed [bpdc_pkg::COORD_W-1:0]    res
);

   localparam int CW_ = bpdc_pkg::COORD_W;
   localparam int TW  = T_FRAC_BITS + 1;
   localparam int DW  = CW_ + 1;
   localparam int PW  = DW + TW + 1;
   localparam int NW  = PW + 1;

   logic signed [CW_-1:0] prev_ff;
   logic signed [DW-1:0]  diff_ff;
   logic signed [CW_-1:0] a2_ff;
   logic signed [PW-1:0]  prod_ff;
   logic signed [CW_-1:0] a3_ff;

   logic signed [DW-1:0]  diff_in;
   logic signed [TW:0]    t_s;
   logic signed [NW-1:0]  base;
   logic signed [NW-1:0]  num;
   logic signed [NW-1:0]  quo;

   // b - a, with b the newer element and a the one before it
   assign diff_in = {cur[CW_-1], cur} - {prev_ff[CW_-1], prev_ff};
   assign t_s     = {1'b0, t};

   always_ff @(posedge clock) begin
      if (advance) begin
         prev_ff <= cur;
      end
      diff_ff <= diff_in;
      a2_ff   <= prev_ff;
      prod_ff <= diff_ff * t_s;
      a3_ff   <= a2_ff;
   end

   // a*ONE + t*(b-a) + ONE/2, floored by the arithmetic shift
   assign base = {{(NW-CW_){a3_ff[CW_-1]}}, a3_ff} <<< T_FRAC_BITS;
   assign num  = base + {{(NW-PW){prod_ff[PW-1]}}, prod_ff}
               + (NW'(1) <<< (T_FRAC_BITS - 1));
   assign quo  = num >>> T_FRAC_BITS;
   assign res  = quo[CW_-1:0];

endmodule

// File: hdl/bpdc_datapath.sv
// Datapath: control point table, interpolation row, two lerp lanes, output word.
// Depends on bpdc_pkg, bpdc_ram and bpdc_lerp.

module bpdc_datapath #(
   parameter int MAX_POINTS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bpdc_pkg::cmd_type                      cmd,
   input  logic [$clog2(MAX_POINTS)-1:0]          rd_addr,
   input  bpdc_pkg::req_type                      req_word,
   input  logic [$clog2(MAX_POINTS+1)-1:0]        active_count,
   output bpdc_pkg::rsp_type                      rsp_word,
   output logic                                   result_done
);

   localparam int IW  = $clog2(MAX_POINTS);
   localparam int TW  = T_FRAC_BITS + 1;
   localparam int CW_ = bpdc_pkg::COORD_W;
   localparam int PW  = 2 * CW_;

   logic [TW-1:0]          t_ff;
   logic [MAX_POINTS-1:0]  filled_ff;
   logic                   filled_q_ff;

   logic                   s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic                   s1_first_ff, s1_last_ff, s1_src_ff;
   logic                   s2_last_ff, s3_last_ff;
   logic [IW-1:0]          s1_addr_ff, s2_addr_ff, s3_addr_ff;

   bpdc_pkg::rsp_type      res_ff;
   bpdc_pkg::rsp_type      rsp_ff;

   logic [31:0]            t_ext, t_one, idx_ext;
   logic [TW-1:0]          t_sat;
   logic                   store_en;
   logic [IW-1:0]          store_addr;
   logic [PW-1:0]          stored_q, work_q, cur;
   logic signed [CW_-1:0]  res_x, res_y;

   // Saturate t at one
   assign t_ext = 32'(req_word.t_value);
   assign t_one = 32'(1) << T_FRAC_BITS;
   assign t_sat = (t_ext > t_one) ? t_one[TW-1:0] : t_ext[TW-1:0];

   // Drop writes at or beyond the point count
   assign idx_ext    = 32'(req_word.point_index);
   assign store_en   = cmd.store_write && (idx_ext < 32'(active_count));
   assign store_addr = idx_ext[IW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
      end else if (store_en) begin
         filled_ff[store_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_t) begin
         t_ff <= t_sat;
      end
      if (cmd.rd_en) begin
         filled_q_ff <= filled_ff[rd_addr];
      end
   end

   bpdc_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_point_ram (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (store_addr),
      .wr_data ({req_word.point_x, req_word.point_y}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (stored_q)
   );

   bpdc_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_row_ram (
      .clock   (clock),
      .wr_en   (s3_vld_ff),
      .wr_addr (s3_addr_ff - 1'b1),
      .wr_data ({res_x, res_y}),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (work_q)
   );

   // Pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= cmd.rd_en;
         s2_vld_ff <= s1_vld_ff && !s1_first_ff;
         s3_vld_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s1_last_ff  <= cmd.last;
      s1_src_ff   <= cmd.src_stored;
      s1_addr_ff  <= rd_addr;
      s2_last_ff  <= s1_last_ff;
      s2_addr_ff  <= s1_addr_ff;
      s3_last_ff  <= s2_last_ff;
      s3_addr_ff  <= s2_addr_ff;
   end

   // Unwritten table entries read as zero
   always_comb begin
      if (s1_src_ff) begin
         cur = filled_q_ff ? stored_q : '0;
      end else begin
         cur = work_q;
      end
   end

   bpdc_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lerp_x (
      .clock   (clock),
      .advance (s1_vld_ff),
      .cur     (cur[PW-1:CW_]),
      .t       (t_ff),
      .res     (res_x)
   );

   bpdc_lerp #(.T_FRAC_BITS(T_FRAC_BITS)) u_lerp_y (
      .clock   (clock),
      .advance (s1_vld_ff),
      .cur     (cur[CW_-1:0]),
      .t       (t_ff),
      .res     (res_y)
   );

   assign result_done = s3_vld_ff && s3_last_ff;

   always_ff @(posedge clock) begin
      if (result_done) begin
         res_ff.curve_x <= res_x;
         res_ff.curve_y <= res_y;
      end
      if (cmd.load_out) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

// File: hdl/bpdc_ctrl.sv
// Controller: accepts words, sequences the interpolation passes, owns result valid.
// Depends on bpdc_pkg for command type and constants.

module bpdc_ctrl #(
   parameter int MAX_POINTS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_action,
   output logic                                req_stall,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [$clog2(MAX_POINTS+1)-1:0]     active_count,
   input  logic                                result_done,
   output bpdc_pkg::cmd_type                   cmd,
   output logic [$clog2(MAX_POINTS)-1:0]       rd_addr
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);
   localparam int GW = bpdc_pkg::GAP_W;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_RUN   = 3'd1;
   localparam logic [2:0] ST_GAP   = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] m_ff, m_in;
   logic [IW-1:0] k_ff, k_in;
   logic          src_ff, src_in;
   logic [GW-1:0] gap_ff, gap_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          pass_end;

   assign pass_end = (32'(k_ff) + 32'd1) == 32'(m_ff);

   always_comb begin
      state_in     = state_ff;
      m_in         = m_ff;
      k_in         = k_ff;
      src_in       = src_ff;
      gap_in       = gap_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_action)
                  bpdc_pkg::ACTION_EVAL: begin
                     cmd.load_t = 1'b1;
                     m_in       = active_count;
                     k_in       = '0;
                     src_in     = 1'b1;
                     state_in   = ST_RUN;
                  end
                  bpdc_pkg::ACTION_WRITE: begin
                     cmd.store_write = 1'b1;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_RUN: begin
            cmd.rd_en      = 1'b1;
            cmd.src_stored = src_ff;
            cmd.first      = (k_ff == '0);
            cmd.last       = (32'(m_ff) == bpdc_pkg::COUNT_MIN) && (32'(k_ff) == 32'd1);
            if (pass_end) begin
               if (32'(m_ff) == bpdc_pkg::COUNT_MIN) begin
                  state_in = ST_DRAIN;
               end else begin
                  m_in   = m_ff - 1'b1;
                  k_in   = '0;
                  src_in = 1'b0;
                  // short rows: hold off until the row tail is written back
                  if (32'(m_ff) < bpdc_pkg::RD_TO_RD_MIN) begin
                     gap_in   = GW'(bpdc_pkg::RD_TO_RD_MIN - 32'(m_ff));
                     state_in = ST_GAP;
                  end
               end
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_GAP: begin
            if (gap_ff == GW'(1)) begin
               state_in = ST_RUN;
            end else begin
               gap_in = gap_ff - 1'b1;
            end
         end
         ST_DRAIN: begin
            if (result_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         m_ff         <= '0;
         k_ff         <= '0;
         src_ff       <= 1'b0;
         gap_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         m_ff         <= m_in;
         k_ff         <= k_in;
         src_ff       <= src_in;
         gap_ff       <= gap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rd_addr   = k_ff;

endmodule

// File: hdl/bezier_point_de_casteljau.sv
// Top level of the de Casteljau curve point evaluator: point count register,
// controller and datapath. Depends on bpdc_pkg, bpdc_ctrl and bpdc_datapath.

// A write word stores one control point (signed Q15.8 x and y) at its index;
// an index at or beyond the point count is dropped. An evaluate word returns
// one word with the curve point at t (16 fraction bits by default, saturated
// at 1.0), built by repeated round-to-nearest interpolation of neighbouring
// points. The block works on one evaluate word at a time. The single read
// ports of the point table and the row memory feed the x and y interpolation
// lanes one element per cycle, with a gap before the next pass on short rows.
// A finished result sits in an output register, so the next word is taken
// while it waits. The control point table reads as zero after reset. Write
// the point count (clamped to 2..MAX_POINTS) only while the block is idle.

module bezier_point_de_casteljau #(
   parameter int MAX_POINTS  = 16,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  bpdc_pkg::req_type                    req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output bpdc_pkg::rsp_type                    rsp_word,
   input  logic                                 csr_wr_en,
   input  logic [bpdc_pkg::COUNT_W-1:0]         csr_wr_data
);

   localparam int IW = $clog2(MAX_POINTS);
   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [bpdc_pkg::COUNT_W-1:0] point_count_ff;
   logic [CW-1:0]                active_count;
   logic [31:0]                  pc_ext;
   bpdc_pkg::cmd_type            cmd;
   logic [IW-1:0]                rd_addr;
   logic                         result_done;

   // Point count register
   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= bpdc_pkg::POINT_COUNT_RESET;
      end else if (csr_wr_en) begin
         point_count_ff <= csr_wr_data;
      end
   end

   // Clamp the count to the supported range
   assign pc_ext = 32'(point_count_ff);
   always_comb begin
      if (pc_ext < bpdc_pkg::COUNT_MIN) begin
         active_count = CW'(bpdc_pkg::COUNT_MIN);
      end else if (pc_ext > MAX_POINTS) begin
         active_count = CW'(MAX_POINTS);
      end else begin
         active_count = CW'(pc_ext);
      end
   end

   bpdc_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_action   (req_word.action),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .active_count (active_count),
      .result_done  (result_done),
      .cmd          (cmd),
      .rd_addr      (rd_addr)
   );

   bpdc_datapath #(
      .MAX_POINTS  (MAX_POINTS),
      .T_FRAC_BITS (T_FRAC_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .rd_addr      (rd_addr),
      .req_word     (req_word),
      .active_count (active_count),
      .rsp_word     (rsp_word),
      .result_done  (result_done)
   );

   // A finished point only appears while an evaluation holds off new words
   a_done_while_busy: assert property (@(posedge clock) disable iff (reset)
      result_done |-> req_stall)
      else $error("result finished while the block was taking words");

   // Row reads stay inside the active point count
   a_rd_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (32'(rd_addr) < 32'(active_count)))
      else $error("row read beyond the point count");

   // Never overwrite a result that is still held on the output
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> !(rsp_valid && rsp_stall))
      else $error("output word overwritten while stalled");

endmodule

// File: tb/bezier_point_de_casteljau_tb.sv
// Self-checking testbench for the de Casteljau curve point evaluator.
// Depends on bpdc_pkg and bezier_point_de_casteljau; drives random words
// with random idling on both channels and checks every curve point.

module bezier_point_de_casteljau_tb;

   localparam int     MAX_PTS      = 16;
   localparam int     T_FRAC       = 16;
   localparam longint T_ONE        = longint'(1) << T_FRAC;
   // Twice the slowest evaluation, the one at sixteen points
   localparam int     DRAIN_CYCLES = 2 * (MAX_PTS * (MAX_PTS + 1) / 2 + 6);
   localparam int     QUIET_LIMIT  = 4000;
   localparam int     RANDOM_WORDS = 1325;
   localparam int     MAX_IDLE     = 17;

   logic                          clock       = 1'b0;
   logic                          reset       = 1'b1;
   logic                          req_valid   = 1'b0;
   logic                          req_stall;
   bpdc_pkg::req_type             req_word    = '0;
   logic                          rsp_valid;
   logic                          rsp_stall   = 1'b0;
   bpdc_pkg::rsp_type             rsp_word;
   logic                          csr_wr_en   = 1'b0;
   logic [bpdc_pkg::COUNT_W-1:0]  csr_wr_data = bpdc_pkg::POINT_COUNT_RESET;

   // Predictor state: point count register and control point table
   logic [bpdc_pkg::COUNT_W-1:0]          model_count = bpdc_pkg::POINT_COUNT_RESET;
   logic signed [bpdc_pkg::COORD_W-1:0]   ctrl_x [MAX_PTS] = '{default: '0};
   logic signed [bpdc_pkg::COORD_W-1:0]   ctrl_y [MAX_PTS] = '{default: '0};

   bpdc_pkg::rsp_type  pending_points [$];   // curve points still owed by the block
   int       fault_count  = 0;
   int       rsp_hold     = 0;     // cycles left in the current receiver stall
   int       quiet_cycles = 0;
   bit       steady_run   = 1'b0;  // set: neither side idles

   always #5 clock = ~clock;

   bezier_point_de_casteljau #(
      .MAX_POINTS  (MAX_PTS),
      .T_FRAC_BITS (T_FRAC)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------

   // Point count in use: the register clamped to 2..MAX_PTS
   function automatic int active_points();
      int c;
      c = int'(model_count);
      if (c < bpdc_pkg::COUNT_MIN) c = bpdc_pkg::COUNT_MIN;
      if (c > MAX_PTS) c = MAX_PTS;
      return c;
   endfunction

   // One interpolation step, rounded to nearest with ties towards plus
   // infinity; an arithmetic shift of a signed value gives the floor.
   function automatic logic signed [bpdc_pkg::COORD_W-1:0] lerp_round(
      input logic signed [bpdc_pkg::COORD_W-1:0] a,
      input logic signed [bpdc_pkg::COORD_W-1:0] b,
      input longint                              t
   );
      longint num;
      longint q;
      num = (T_ONE - t) * longint'(a) + t * longint'(b) + (T_ONE >>> 1);
      q   = num >>> T_FRAC;
      return q[bpdc_pkg::COORD_W-1:0];
   endfunction

   // Advance the predictor by one accepted word
   function automatic void predict_curve_word(input bpdc_pkg::req_type w);
      int                                    n;
      longint                                t;
      logic signed [bpdc_pkg::COORD_W-1:0]   row_x [MAX_PTS];
      logic signed [bpdc_pkg::COORD_W-1:0]   row_y [MAX_PTS];
      bpdc_pkg::rsp_type                     pt;
      n = active_points();
      if (w.action == bpdc_pkg::ACTION_WRITE) begin
         // drop a write at or beyond the point count
         if (int'(w.point_index) < n) begin
            ctrl_x[w.point_index] = w.point_x;
            ctrl_y[w.point_index] = w.point_y;
         end
      end else begin
         t = longint'(w.t_value);
         if (t > T_ONE) t = T_ONE;
         row_x = ctrl_x;
         row_y = ctrl_y;
         // shrink the row by one point per pass until one point is left
         for (int j = 1; j < n; j++) begin
            for (int i = 0; i + j < n; i++) begin
               row_x[i] = lerp_round(row_x[i], row_x[i + 1], t);
               row_y[i] = lerp_round(row_y[i], row_y[i + 1], t);
            end
         end
         pt.curve_x = row_x[0];
         pt.curve_y = row_y[0];
         pending_points = {pending_points, pt};
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic signed [bpdc_pkg::COORD_W-1:0] rand_coord();
      int v;
      case ($urandom_range(3, 0))
         0:       v = int'($urandom);
         1:       v = ($urandom_range(1, 0) != 0) ? 32'h007F_FFFF : 32'hFF80_0000;
         2:       v = int'($urandom_range(4095, 0)) - 2048;
         default: v = int'($urandom);
      endcase
      return v[bpdc_pkg::COORD_W-1:0];
   endfunction

   function automatic logic [bpdc_pkg::T_FIELD_W-1:0] rand_t();
      int v;
      case ($urandom_range(7, 0))
         0: v = int'($urandom_range(131071, 0));
         1: begin
            case ($urandom_range(5, 0))
               0:       v = 0;
               1:       v = 1;
               2:       v = 65535;
               3:       v = 65536;
               4:       v = 65537;
               default: v = 131071;
            endcase
         end
         default: v = int'($urandom_range(65536, 0));
      endcase
      return v[bpdc_pkg::T_FIELD_W-1:0];
   endfunction

   // Write word; t is unused by writes, so fill it with noise
   function automatic bpdc_pkg::req_type write_word(
      input int                                  idx,
      input logic signed [bpdc_pkg::COORD_W-1:0] x,
      input logic signed [bpdc_pkg::COORD_W-1:0] y
   );
      bpdc_pkg::req_type w;
      w.action      = bpdc_pkg::ACTION_WRITE;
      w.point_index = idx[bpdc_pkg::IDX_W-1:0];
      w.point_x     = x;
      w.point_y     = y;
      w.t_value     = bpdc_pkg::T_FIELD_W'($urandom);
      return w;
   endfunction

   // Evaluate word; index and coordinates are unused, so fill them with noise
   function automatic bpdc_pkg::req_type eval_word(
      input logic [bpdc_pkg::T_FIELD_W-1:0] t
   );
      bpdc_pkg::req_type w;
      w.action      = bpdc_pkg::ACTION_EVAL;
      w.point_index = bpdc_pkg::IDX_W'($urandom);
      w.point_x     = bpdc_pkg::COORD_W'($urandom);
      w.point_y     = bpdc_pkg::COORD_W'($urandom);
      w.t_value     = t;
      return w;
   endfunction

   // Present one word after a random gap and hold it until it is taken.
   // Called and returns at a rising edge; valid stays high on return so a
   // following word with no gap goes out back to back.
   task automatic send_word(input bpdc_pkg::req_type w);
      int gap;
      gap = steady_run ? 0 : $urandom_range(MAX_IDLE, 0);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      predict_curve_word(w);
   endtask

   // Wait for every owed point, then long enough for any work still in flight
   task automatic wait_drained();
      while (pending_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the point count register once the block is idle
   task automatic set_point_count(input logic [bpdc_pkg::COUNT_W-1:0] value);
      req_valid <= 1'b0;
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_count = value;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // The table is cleared at reset, so every curve point is the origin
   task automatic test_cleared_table();
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(0)));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(32768)));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(65536)));
   endtask

   // Extreme coordinates under the reset count of four, writes beyond the
   // count, and t at both ends, just inside them and above one
   task automatic test_field_extremes();
      send_word(write_word(0, 24'sh7FFFFF, 24'sh800000));
      send_word(write_word(1, 24'sh800000, 24'sh7FFFFF));
      send_word(write_word(2, 24'sh000000, -24'sd1));
      send_word(write_word(3, 24'sh7FFFFF, 24'sh7FFFFF));
      send_word(write_word(4, 24'sh123456, 24'sh654321));
      send_word(write_word(15, 24'sh7FFFFF, 24'sh800000));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(0)));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(1)));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(32768)));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(65535)));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(65536)));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(131071)));
   endtask

   // Count register at and beyond both ends of its range
   task automatic test_count_extremes();
      set_point_count(bpdc_pkg::COUNT_W'(0));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(32768)));
      set_point_count(bpdc_pkg::COUNT_W'(1));
      send_word(write_word(1, -24'sd256, 24'sd512));
      send_word(write_word(2, 24'sh7FFFFF, 24'sh7FFFFF));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(21845)));
      set_point_count(bpdc_pkg::COUNT_W'(31));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(21845)));
      set_point_count(bpdc_pkg::COUNT_W'(16));
      send_word(write_word(15, 24'sh7FFFFF, 24'sh800000));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(65536)));
      set_point_count(bpdc_pkg::COUNT_W'(17));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(49152)));
      set_point_count(bpdc_pkg::COUNT_W'(2));
      send_word(eval_word(bpdc_pkg::T_FIELD_W'(16384)));
   endtask

   // Random curves: per phase pick a count, load every point in use, then
   // mix evaluations with rewrites and the odd out-of-range write.
   // Counts are mostly small to keep evaluations short.
   task automatic test_random_curves();
      int sent;
      int n;
      int idx;
      int code;
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         case ($urandom_range(9, 0))
            0, 1, 2, 3, 4, 5: code = $urandom_range(5, 2);
            6:                code = MAX_PTS;
            7:                code = $urandom_range(MAX_PTS - 1, 6);
            8:                code = $urandom_range(1, 0);
            default:          code = $urandom_range(31, MAX_PTS + 1);
         endcase
         set_point_count(code[bpdc_pkg::COUNT_W-1:0]);
         steady_run = ($urandom_range(3, 0) == 0);
         n = active_points();
         for (int i = 0; i < n; i++) begin
            send_word(write_word(i, rand_coord(), rand_coord()));
            sent++;
         end
         repeat ($urandom_range(12, 3)) begin
            case ($urandom_range(9, 0))
               0: begin
                  idx = $urandom_range(MAX_PTS - 1, 0);
                  send_word(write_word(idx, rand_coord(), rand_coord()));
                  sent++;
               end
               1, 2: begin
                  send_word(write_word($urandom_range(n - 1, 0), rand_coord(),
                                       rand_coord()));
                  sent++;
               end
               default: begin
                  send_word(eval_word(rand_t()));
                  sent++;
               end
            endcase
         end
      end
      steady_run = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Checking and receiver idling
   // ------------------------------------------------------------------

   function automatic void log_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%0t: %s", $time, msg);
   endfunction

   function automatic void check_curve_point(input bpdc_pkg::rsp_type got);
      bpdc_pkg::rsp_type want;
      if (pending_points.size() == 0) begin
         log_fault($sformatf("unexpected curve point x=%0d y=%0d",
                             got.curve_x, got.curve_y));
         return;
      end
      want = pending_points.pop_front();
      if (got.curve_x !== want.curve_x)
         log_fault($sformatf("curve_x: expected %0d, got %0d",
                             want.curve_x, got.curve_x));
      if (got.curve_y !== want.curve_y)
         log_fault($sformatf("curve_y: expected %0d, got %0d",
                             want.curve_y, got.curve_y));
   endfunction

   // Check each accepted word, then hold the stall for a random count so
   // that stalls land on every phase of the following evaluation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         check_curve_point(rsp_word);
         rsp_hold = steady_run ? 0 : $urandom_range(MAX_IDLE, 0);
         rsp_stall <= (rsp_hold != 0);
      end else if (rsp_hold != 0) begin
         rsp_hold--;
         if (rsp_hold == 0) rsp_stall <= 1'b0;
      end
   end

   // Watchdog: end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_cleared_table();
      test_field_extremes();
      test_count_extremes();
      test_random_curves();
      req_valid <= 1'b0;
      wait_drained();
      if (fault_count == 0 && pending_points.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/bpdc_pkg.sv
hdl/bpdc_ram.sv
hdl/bpdc_lerp.sv
hdl/bpdc_datapath.sv
hdl/bpdc_ctrl.sv
hdl/bezier_point_de_casteljau.sv
tb/bezier_point_de_casteljau_tb.sv
